/* src/hex_unesc_pkg.sv */
// Shared constants and the hex nibble decode for the escape decoder.
package hex_unesc_pkg;

    localparam logic [7:0] ESC_CHAR = 8'd92;
    localparam logic [7:0] HEX_MARK = 8'd120;
    localparam logic [7:0] UC_A     = 8'd65;
    localparam logic [7:0] UC_F     = 8'd70;
    localparam logic [7:0] LC_A     = 8'd97;
    localparam logic [7:0] LC_F     = 8'd102;
    localparam logic [7:0] DIG_0    = 8'd48;
    localparam logic [7:0] DIG_9    = 8'd57;

    localparam int unsigned MAX_RES = 3;
    localparam int unsigned CNT_W   = 2;

    typedef logic [7:0] byte_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Non-hex characters decode to zero.
    function automatic logic [3:0] nibble_of(input byte_t c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= UC_A && c <= UC_F)
            begin
                d = c - UC_A + 8'd10;
            end
            else if (c >= LC_A && c <= LC_F)
            begin
                d = c - LC_A + 8'd10;
            end
            else if (c >= DIG_0 && c <= DIG_9)
            begin
                d = c - DIG_0;
            end
            return d[3:0];
        end
    endfunction

endpackage

/* src/hex_escape_unescaper.sv */
// Backslash hex escape decoder: one raw byte in, zero to three bytes out.
//
//   channel | handshake          | payload
//   --------+--------------------+----------------------------------
//   in      | in_valid/in_ready  | in_byte, last_in
//   out     | out_valid/out_ready| out_byte, run_last, message_end
//
// An item is decoded in the cycle it is accepted; its results land in a
// three-entry result register and leave one per cycle while out_ready is high.
// Items giving zero or one result flow at one per cycle while out_ready is
// high; an item giving more than one holds in_ready low while several remain.
// A new item is taken while the last pending result is being taken.
// Reset returns the parser to plain text and empties the result register.
module hex_escape_unescaper
    import hex_unesc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       last_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       message_end
);

    typedef enum logic [1:0] {
        PH_TEXT   = 2'd0,
        PH_ESC    = 2'd1,
        PH_HEX_HI = 2'd2,
        PH_HEX_LO = 2'd3
    } phase_t;

    phase_t phase_reg, phase_next;
    byte_t  pend_reg, pend_next;
    byte_t  res_reg  [MAX_RES];
    byte_t  res_next [MAX_RES];
    cnt_t   rem_reg, rem_next;
    logic   end_reg, end_next;

    byte_t  dec_res [MAX_RES];
    cnt_t   dec_cnt;
    phase_t dec_phase;

    logic in_fire;
    logic out_fire;

    assign out_valid   = (rem_reg != '0);
    assign out_byte    = res_reg[0];
    assign run_last    = (rem_reg == cnt_t'(1));
    assign message_end = run_last && end_reg;
    assign out_fire    = out_valid && out_ready;
    assign in_ready    = (rem_reg == '0) || ((rem_reg == cnt_t'(1)) && out_ready);
    assign in_fire     = in_valid && in_ready;

    always_comb
    begin
        dec_res[0] = in_byte;
        dec_res[1] = HEX_MARK;
        dec_res[2] = in_byte;
        dec_cnt    = '0;
        dec_phase  = phase_reg;
        pend_next  = pend_reg;
        case (phase_reg)
            PH_TEXT:
            begin
                if (in_byte == ESC_CHAR && !last_in)
                begin
                    dec_phase = PH_ESC;
                end
                else
                begin
                    dec_cnt = cnt_t'(1);
                end
            end
            PH_ESC:
            begin
                if (in_byte == HEX_MARK)
                begin
                    if (last_in)
                    begin
                        dec_res[0] = ESC_CHAR;
                        dec_cnt    = cnt_t'(2);
                    end
                    else
                    begin
                        dec_phase = PH_HEX_HI;
                    end
                end
                else
                begin
                    dec_cnt   = cnt_t'(1);
                    dec_phase = PH_TEXT;
                end
            end
            PH_HEX_HI:
            begin
                pend_next = in_byte;
                if (last_in)
                begin
                    dec_res[0] = ESC_CHAR;
                    dec_cnt    = cnt_t'(3);
                end
                else
                begin
                    dec_phase = PH_HEX_LO;
                end
            end
            PH_HEX_LO:
            begin
                dec_res[0] = {nibble_of(pend_reg), nibble_of(in_byte)};
                dec_cnt    = cnt_t'(1);
                dec_phase  = PH_TEXT;
            end
            default:
            begin
                dec_phase = PH_TEXT;
            end
        endcase
        if (last_in)
        begin
            dec_phase = PH_TEXT;
        end
        if (!in_fire)
        begin
            pend_next = pend_reg;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        res_next[0] = res_reg[1];
        res_next[1] = res_reg[2];
        res_next[2] = res_reg[2];
        rem_next    = rem_reg;
        end_next    = end_reg;
        if (out_fire)
        begin
            rem_next = rem_reg - cnt_t'(1);
        end
        else
        begin
            res_next[0] = res_reg[0];
            res_next[1] = res_reg[1];
        end
        if (in_fire)
        begin
            phase_next = dec_phase;
            if (dec_cnt != '0)
            begin
                res_next = dec_res;
                rem_next = dec_cnt;
                end_next = last_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TEXT;
            rem_reg   <= '0;
            end_reg   <= 1'b0;
            pend_reg  <= '0;
            res_reg   <= '{default: '0};
        end
        else
        begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            end_reg   <= end_next;
            pend_reg  <= pend_next;
            res_reg   <= res_next;
        end
    end

`ifndef SYNTHESIS
    a_last_resets_phase: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last_in |=> phase_reg == PH_TEXT)
        else $error("phase not cleared after message end");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last_in |=> out_valid && end_reg)
        else $error("message end item produced no result");

    a_lo_from_hi: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEX_LO && $past(phase_reg) != PH_HEX_LO
        |-> $past(phase_reg) == PH_HEX_HI)
        else $error("low nibble phase entered without high nibble");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(rem_reg))
        else $error("pending results changed while output stalled");

    a_no_take_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg > cnt_t'(1) |-> !in_ready)
        else $error("input taken while several results pending");
`endif

endmodule
